// File: design/arpc_pkg.sv
// shared types and constants for the arp responder with cache
package arpc_pkg;

  localparam int unsigned MacW = 48;
  localparam int unsigned IpW  = 32;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_REPLY = 2'd1;
  localparam logic [1:0] ACT_BCAST = 2'd2;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_REQ   = 2'd1;
  localparam logic [1:0] OP_REP   = 2'd2;

  localparam logic [15:0] HW_ETHER   = 16'h0001;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [15:0] ARP_REQ    = 16'h0001;
  localparam logic [15:0] ARP_REP    = 16'h0002;
  localparam logic [15:0] MIN_LEN    = 16'd28;
  localparam logic [7:0]  HW_LEN6    = 8'd6;
  localparam logic [7:0]  PROTO_LEN4 = 8'd4;
  localparam logic [MacW-1:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  // classified work handed from front to back
  typedef enum logic [1:0] {
    JOB_NONE  = 2'd0,
    JOB_REPLY = 2'd1,
    JOB_LEARN = 2'd2,
    JOB_QUERY = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t       kind;
    logic [MacW-1:0] mac;
    logic [IpW-1:0]  ip;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_READ  = 3'd1,
    BK_CHECK = 3'd2,
    BK_FETCH = 3'd3,
    BK_EMIT  = 3'd4
  } back_state_t;

  // register addresses (8-byte spacing, index in bits [3])
  localparam logic [3:0] ADDR_OWN_MAC = 4'h0;
  localparam logic [3:0] ADDR_OWN_IP  = 4'h8;

endpackage

// File: design/arp_responder_with_cache_core.sv
// top level of the arp responder with address cache
//  channel   | handshake            | beat
//  input     | start / busy         | one arp message or resolve query
//  result    | done strobe          | one result per input item, one cycle
//  config    | apb psel/penable     | own_mac at 0x0, own_ip at 0x8
// a message goes from the job queue register straight to the emit state; a
// query also passes read and check for each scanned entry (and fetch on a
// hit), one read of the one-port cache memory per entry. busy is high from
// the accept until the result beat. rst is synchronous and clears the cache
// count; the cache memories need no clearing. the result cannot be stalled.
module arp_responder_with_cache_core import arpc_pkg::*; #(
  parameter int unsigned ENTRIES = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [63:0]     pwdata,
  output logic [63:0]     prdata,
  output logic            pready,
  input  logic            start,
  output logic            busy,
  input  logic            kind,
  input  logic [15:0]     frame_len,
  input  logic [15:0]     hw_type,
  input  logic [15:0]     proto_type,
  input  logic [7:0]      hw_len,
  input  logic [7:0]      proto_len,
  input  logic [15:0]     opcode,
  input  logic [47:0]     sender_mac,
  input  logic [31:0]     sender_ip,
  input  logic [31:0]     target_ip,
  input  logic [31:0]     query_ip,
  output logic            done,
  output logic [1:0]      action,
  output logic [1:0]      out_opcode,
  output logic [47:0]     out_sender_mac,
  output logic [31:0]     out_sender_ip,
  output logic [47:0]     out_target_mac,
  output logic [31:0]     out_target_ip,
  output logic [47:0]     resolved_mac,
  output logic            hit
);

  logic [MacW-1:0] own_mac;
  logic [IpW-1:0]  own_ip;
  job_t            fjob, qjob;
  logic            qvalid, bready, pend;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      own_ip  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_OWN_MAC: own_mac <= pwdata[MacW-1:0];
        ADDR_OWN_IP:  own_ip  <= pwdata[IpW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_OWN_MAC: prdata = {16'd0, own_mac};
      ADDR_OWN_IP:  prdata = {32'd0, own_ip};
      default:      prdata = '0;
    endcase
  end

  arpc_front u_front (
    .kind(kind), .frame_len(frame_len), .hw_type(hw_type),
    .proto_type(proto_type), .hw_len(hw_len), .proto_len(proto_len),
    .opcode(opcode), .sender_mac(sender_mac), .sender_ip(sender_ip),
    .target_ip(target_ip), .query_ip(query_ip), .own_ip(own_ip), .job(fjob)
  );

  // one-entry job queue between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      qvalid <= 1'b0;
      pend   <= 1'b0;
    end else begin
      if (start && !busy) begin
        qvalid <= 1'b1;
        pend   <= 1'b1;
      end else if (qvalid && bready) begin
        qvalid <= 1'b0;
      end
      if (done) begin
        pend <= 1'b0;
      end
    end
    if (start && !busy) begin
      qjob <= fjob;
    end
  end

  assign busy = pend;

  arpc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk(clk), .rst(rst), .job_valid(qvalid), .job(qjob), .job_ready(bready),
    .own_mac(own_mac), .own_ip(own_ip), .done(done), .action(action),
    .out_opcode(out_opcode), .out_sender_mac(out_sender_mac),
    .out_sender_ip(out_sender_ip), .out_target_mac(out_target_mac),
    .out_target_ip(out_target_ip), .resolved_mac(resolved_mac), .hit(hit)
  );

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result without item");
  a_no_double_queue: assert property (@(posedge clk) disable iff (rst)
    qvalid |-> pend) else $error("queued job without pending item");
`endif

endmodule

// File: design/arpc_ram.sv
// generic single-port ram with registered read
module arpc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/arpc_front.sv
// front end: checks and classifies an item into a queued job
module arpc_front import arpc_pkg::*; (
  input  logic            kind,
  input  logic [15:0]     frame_len,
  input  logic [15:0]     hw_type,
  input  logic [15:0]     proto_type,
  input  logic [7:0]      hw_len,
  input  logic [7:0]      proto_len,
  input  logic [15:0]     opcode,
  input  logic [MacW-1:0] sender_mac,
  input  logic [IpW-1:0]  sender_ip,
  input  logic [IpW-1:0]  target_ip,
  input  logic [IpW-1:0]  query_ip,
  input  logic [IpW-1:0]  own_ip,
  output job_t            job
);

  logic valid_msg;

  always_comb begin
    valid_msg = (frame_len >= MIN_LEN) && (hw_type == HW_ETHER) &&
                (proto_type == PROTO_IPV4) && (hw_len == HW_LEN6) &&
                (proto_len == PROTO_LEN4) && (target_ip == own_ip);
    job.mac  = sender_mac;
    job.ip   = sender_ip;
    job.kind = JOB_NONE;
    if (kind) begin
      job.kind = JOB_QUERY;
      job.ip   = query_ip;
    end else if (valid_msg && opcode == ARP_REQ) begin
      job.kind = JOB_REPLY;
    end else if (valid_msg && opcode == ARP_REP) begin
      job.kind = JOB_LEARN;
    end
  end

endmodule

// File: design/arpc_back.sv
// back end: cache append, sequential lookup and result formation
module arpc_back import arpc_pkg::*; #(
  parameter int unsigned ENTRIES = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  job_t            job,
  output logic            job_ready,
  input  logic [MacW-1:0] own_mac,
  input  logic [IpW-1:0]  own_ip,
  output logic            done,
  output logic [1:0]      action,
  output logic [1:0]      out_opcode,
  output logic [MacW-1:0] out_sender_mac,
  output logic [IpW-1:0]  out_sender_ip,
  output logic [MacW-1:0] out_target_mac,
  output logic [IpW-1:0]  out_target_ip,
  output logic [MacW-1:0] resolved_mac,
  output logic            hit
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  back_state_t     state, state_next;
  job_t            cur, cur_next;
  logic [CW-1:0]   entry_count, entry_count_next;
  logic [CW-1:0]   idx, idx_next;
  logic            found, found_next;
  logic            we;
  logic [AW-1:0]   addr;
  logic [IpW-1:0]  ip_rd;
  logic [MacW-1:0] mac_rd;
  logic            emit;

  arpc_ram #(.WIDTH(IpW), .DEPTH(ENTRIES)) u_ip_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(cur.ip), .rdata(ip_rd)
  );
  arpc_ram #(.WIDTH(MacW), .DEPTH(ENTRIES)) u_mac_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(cur.mac), .rdata(mac_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      entry_count <= '0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
    end
    cur   <= cur_next;
    idx   <= idx_next;
    found <= found_next;
  end

  always_comb begin
    state_next       = state;
    cur_next         = cur;
    entry_count_next = entry_count;
    idx_next         = idx;
    found_next       = found;
    we               = 1'b0;
    addr             = idx[AW-1:0];
    job_ready        = 1'b0;
    emit             = 1'b0;
    case (state)
      BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          cur_next   = job;
          idx_next   = '0;
          found_next = 1'b0;
          if (job.kind == JOB_QUERY) begin
            state_next = (entry_count == '0) ? BK_EMIT : BK_READ;
          end else begin
            state_next = BK_EMIT;
          end
        end
      end
      // address idx presented this cycle, data next cycle
      BK_READ: begin
        state_next = BK_CHECK;
      end
      BK_CHECK: begin
        if (ip_rd == cur.ip) begin
          found_next = 1'b1;
          state_next = BK_FETCH;
        end else if (idx + 1'b1 >= entry_count) begin
          state_next = BK_EMIT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = BK_READ;
        end
      end
      BK_FETCH: begin
        cur_next.mac = mac_rd;
        state_next   = BK_EMIT;
      end
      BK_EMIT: begin
        emit       = 1'b1;
        state_next = BK_IDLE;
        if (cur.kind == JOB_LEARN && entry_count < CW'(ENTRIES)) begin
          we               = 1'b1;
          addr             = entry_count[AW-1:0];
          entry_count_next = entry_count + 1'b1;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  logic [MacW-1:0] qmac;
  logic            qmiss;

  always_comb begin
    qmac           = found ? cur.mac : MAC_BCAST;
    qmiss          = (qmac == MAC_BCAST);
    done           = emit;
    action         = ACT_NONE;
    out_opcode     = OP_NONE;
    out_sender_mac = '0;
    out_sender_ip  = '0;
    out_target_mac = '0;
    out_target_ip  = '0;
    resolved_mac   = '0;
    hit            = 1'b0;
    if (cur.kind == JOB_REPLY) begin
      action         = ACT_REPLY;
      out_opcode     = OP_REP;
      out_sender_mac = own_mac;
      out_sender_ip  = own_ip;
      out_target_mac = cur.mac;
      out_target_ip  = cur.ip;
    end else if (cur.kind == JOB_QUERY) begin
      resolved_mac = qmac;
      hit          = found;
      if (qmiss) begin
        action         = ACT_BCAST;
        out_opcode     = OP_REQ;
        out_sender_mac = own_mac;
        out_sender_ip  = own_ip;
        out_target_mac = MAC_BCAST;
        out_target_ip  = cur.ip;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(ENTRIES)) else $error("entry count overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    entry_count != $past(entry_count) |-> $past(we)) else $error("count moved without write");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> state == BK_IDLE) else $error("emit not followed by idle");
  a_found_query: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> cur.kind == JOB_QUERY) else $error("hit on non-query");
`endif

endmodule
